>>> hw/rtl/safp_pkg.sv
`default_nettype none

package safp_pkg;

  // default number of servos tracked
  localparam int SERVO_COUNT_DFLT = 16;

  // frame layout
  localparam logic [3:0] POS_IDLE      = 4'd0;
  localparam logic [3:0] POS_FIRST     = 4'd1;
  localparam logic [3:0] POS_ID_LAST   = 4'd3;
  localparam logic [3:0] POS_MARK      = 4'd4;
  localparam logic [3:0] POS_ANG_FIRST = 4'd5;
  localparam logic [3:0] POS_ANG_LAST  = 4'd8;
  localparam logic [3:0] POS_END       = 4'd9;
  localparam logic [3:0] POS_FULL      = 4'd10;

  // frame characters
  localparam logic [7:0] CH_START = 8'h23;
  localparam logic [7:0] CH_END   = 8'h21;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // valid angle window
  localparam logic [15:0] ANGLE_MIN = 16'd500;
  localparam logic [15:0] ANGLE_MAX = 16'd2500;

  // input item codes
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic [7:0] query_id;
  } safp_in_t;

  typedef struct packed {
    logic        fresh;
    logic        angle_ok;
    logic [15:0] angle_value;
  } safp_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_HOLD
  } safp_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/servo_angle_frame_parser.sv
`default_nettype none

// Parses ten-byte servo reply frames '#iiiPaaaa!' from a received byte stream
// and keeps the last angle per servo in a small RAM with a fresh flag per
// servo. A '#' always restarts a frame; a frame with 'P' in its fifth byte,
// '!' as its last byte and an id below SERVO_COUNT updates that servo. A
// query transfer returns the fresh flag, a 500..2500 range check of a fresh
// angle and the angle (zero unless fresh and in range), then clears the flag.
// A received byte produces no result; a query goes through the registered
// read of the angle RAM and then the output register, which holds it while
// the output stalls. Only one item is in flight at a time.
module servo_angle_frame_parser #(
  parameter int SERVO_COUNT = safp_pkg::SERVO_COUNT_DFLT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire safp_pkg::safp_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output safp_pkg::safp_out_t      out_data
);

  import safp_pkg::*;

  localparam int         IDXW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam logic [8:0] NUM  = 9'(SERVO_COUNT);

  safp_state_t             state_r, state_nxt;
  logic [3:0]              pos_r, pos_nxt;
  logic [7:0]              id_r, id_nxt;
  logic [15:0]             ang_r, ang_nxt;
  logic                    mark_ok_r, mark_ok_nxt;
  logic [SERVO_COUNT-1:0]  fresh_r, fresh_nxt;
  logic                    qfresh_r, qfresh_nxt;
  safp_out_t               out_r, out_nxt;

  logic                    in_xfer;
  logic [7:0]              b;
  logic [7:0]              dig8;
  logic [15:0]             dig16;
  logic [IDXW-1:0]         qidx;
  logic                    qid_ok;
  logic                    ram_we;
  logic                    ram_re;
  logic [15:0]             ram_rdata;
  logic                    in_range;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_HOLD);
  assign out_data  = out_r;

  // digit values wrap like unsigned subtraction
  assign b     = in_data.rx_byte;
  assign dig8  = b - CH_ZERO;
  assign dig16 = {8'h00, b} - {8'h00, CH_ZERO};

  assign qidx   = in_data.query_id[IDXW-1:0];
  assign qid_ok = ({1'b0, in_data.query_id} < NUM);
  assign ram_re = in_xfer && (in_data.func == FUNC_QUERY);

  assign in_range = (ram_rdata >= ANGLE_MIN) && (ram_rdata <= ANGLE_MAX);

  // angle store
  safp_ram #(
    .WIDTH (16),
    .DEPTH (SERVO_COUNT)
  ) u_angle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (id_r[IDXW-1:0]),
    .wdata (ang_r),
    .re    (ram_re),
    .raddr (qidx),
    .rdata (ram_rdata)
  );

  // control and frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= POS_IDLE;
      fresh_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    ang_r     <= ang_nxt;
    mark_ok_r <= mark_ok_nxt;
    qfresh_r  <= qfresh_nxt;
    out_r     <= out_nxt;
  end

  // frame collection and query sequencing
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    id_nxt      = id_r;
    ang_nxt     = ang_r;
    mark_ok_nxt = mark_ok_r;
    fresh_nxt   = fresh_r;
    qfresh_nxt  = qfresh_r;
    out_nxt     = out_r;
    ram_we      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.func == FUNC_QUERY) begin
            // look up the flag now, angle arrives next cycle
            qfresh_nxt = qid_ok && fresh_r[qidx];
            if (qid_ok) begin
              fresh_nxt[qidx] = 1'b0;
            end
            state_nxt = ST_READ;
          end else if (b == CH_START) begin
            pos_nxt     = POS_FIRST;
            id_nxt      = 8'h00;
            ang_nxt     = 16'h0000;
            mark_ok_nxt = 1'b0;
          end else if ((pos_r != POS_IDLE) && (pos_r != POS_FULL)) begin
            pos_nxt = pos_r + 4'd1;
            if (pos_r <= POS_ID_LAST) begin
              id_nxt = 8'((id_r << 3) + (id_r << 1)) + dig8;
            end
            if (pos_r == POS_MARK) begin
              mark_ok_nxt = (b == CH_P);
            end
            if ((pos_r >= POS_ANG_FIRST) && (pos_r <= POS_ANG_LAST)) begin
              ang_nxt = 16'((ang_r << 3) + (ang_r << 1)) + dig16;
            end
            if ((pos_r == POS_END) && (b == CH_END)) begin
              pos_nxt = POS_IDLE;
              if (mark_ok_r && ({1'b0, id_r} < NUM)) begin
                ram_we = 1'b1;
                fresh_nxt[id_r[IDXW-1:0]] = 1'b1;
              end
            end
          end
        end
      end
      ST_READ: begin
        // build the result from the RAM read
        out_nxt.fresh       = qfresh_r;
        out_nxt.angle_ok    = qfresh_r && in_range;
        out_nxt.angle_value = (qfresh_r && in_range) ? ram_rdata : 16'h0000;
        state_nxt           = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/safp_ram.sv
`default_nettype none

module safp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
